@@ rtl/core/bpsd_pkg.sv @@
//------------------------------------------------------------------------------
// bpsd_pkg
// Shared types and constants of the binary patch stream decoder.
//------------------------------------------------------------------------------
`default_nettype none

package bpsd_pkg;

    localparam int ADDR_BITS = 32;

    typedef logic [ADDR_BITS-1:0] t_addr;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_COPY  = 2'd1;
    localparam logic [1:0] OP_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_DELETE    = 2'd1;
    localparam logic [1:0] ERR_EQUAL     = 2'd2;
    localparam logic [1:0] ERR_BACKTRACK = 2'd3;

    localparam logic [2:0] CFG_ESCAPE    = 3'd0;
    localparam logic [2:0] CFG_MODIFY    = 3'd1;
    localparam logic [2:0] CFG_INSERT    = 3'd2;
    localparam logic [2:0] CFG_DELETE    = 3'd3;
    localparam logic [2:0] CFG_EQUAL     = 3'd4;
    localparam logic [2:0] CFG_BACKTRACK = 3'd5;

    localparam logic [7:0] RST_ESCAPE    = 8'd167;
    localparam logic [7:0] RST_MODIFY    = 8'd166;
    localparam logic [7:0] RST_INSERT    = 8'd165;
    localparam logic [7:0] RST_DELETE    = 8'd164;
    localparam logic [7:0] RST_EQUAL     = 8'd163;
    localparam logic [7:0] RST_BACKTRACK = 8'd162;

    localparam logic [7:0] LEAD_SHORT = 8'd252;
    localparam logic [7:0] LEAD_16    = 8'd253;
    localparam logic [7:0] LEAD_32    = 8'd254;
    localparam logic [7:0] LEAD_BAD   = 8'd255;

    localparam logic [2:0] OFF_MAX_BYTES = 3'd5;

    typedef struct packed {
        logic [7:0] esc_code;
        logic [7:0] mod_code;
        logic [7:0] ins_code;
        logic [7:0] del_code;
        logic [7:0] eql_code;
        logic [7:0] bkt_code;
    } t_cfg;

    typedef struct packed {
        logic        two;
        logic [1:0]  kind;
        logic [31:0] dest0;
        logic [31:0] dest1;
        logic [31:0] src;
        logic [7:0]  data0;
        logic [7:0]  data1;
        logic [30:0] len;
        logic [1:0]  err;
    } t_pair;

endpackage

`default_nettype wire

@@ rtl/core/bpsd_decode.sv @@
//------------------------------------------------------------------------------
// bpsd_decode
// Input register, decoder state and per-byte decode into a result pair.
//------------------------------------------------------------------------------
`default_nettype none

module bpsd_decode (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bpsd_pkg::t_cfg i_cfg,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_patch_byte,
    output logic                o_stall,
    input  wire logic           i_q_full,
    output logic                o_push,
    output bpsd_pkg::t_pair     o_pair
);
    import bpsd_pkg::*;

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_MODIFY,
        MODE_INSERT,
        MODE_DELETE,
        MODE_EQUAL,
        MODE_BACKTRACK
    } t_mode;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_mode       r_mode;
    t_mode       n_mode;
    logic        r_pend;
    logic        n_pend;
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;
    logic [2:0]  r_need;
    logic [2:0]  n_need;
    t_addr       r_orig;
    t_addr       n_orig;
    t_addr       r_dest;
    t_addr       n_dest;
    logic [23:0] r_acc;

    logic        fire;
    logic        accept;
    logic        acc_we;
    logic [1:0]  nres;
    t_mode       cmd;
    logic        is_off;
    logic        lead;
    logic        stuck;
    logic [2:0]  need_eff;
    logic [2:0]  cnt_inc;
    logic        complete;
    logic [31:0] off_val;
    logic [1:0]  off_err;
    logic [1:0]  nlit;
    logic [7:0]  lit0;
    logic [7:0]  lit1;
    t_pair       pair;
    logic [7:0]  b;

    assign b       = r_in_byte;
    assign fire    = r_in_valid && !i_q_full;
    assign o_stall = r_in_valid && !fire;
    assign accept  = i_valid && !o_stall;
    assign o_push  = fire && (nres != 2'd0);
    assign o_pair  = pair;

    always_comb begin
        if (b == i_cfg.mod_code) begin
            cmd = MODE_MODIFY;
        end else if (b == i_cfg.ins_code) begin
            cmd = MODE_INSERT;
        end else if (b == i_cfg.del_code) begin
            cmd = MODE_DELETE;
        end else if (b == i_cfg.eql_code) begin
            cmd = MODE_EQUAL;
        end else if (b == i_cfg.bkt_code) begin
            cmd = MODE_BACKTRACK;
        end else begin
            cmd = MODE_NONE;
        end
    end

    always_comb begin
        is_off  = (r_mode == MODE_DELETE) || (r_mode == MODE_EQUAL) ||
                  (r_mode == MODE_BACKTRACK);
        lead    = (r_cnt == 3'd0);
        stuck   = ((r_cnt != 3'd0) && (r_cnt == r_need)) || (r_cnt >= OFF_MAX_BYTES);
        cnt_inc = r_cnt + 3'd1;
        if (lead) begin
            if (b == LEAD_32) begin
                need_eff = 3'd5;
            end else if (b == LEAD_16) begin
                need_eff = 3'd3;
            end else if (b == LEAD_SHORT) begin
                need_eff = 3'd2;
            end else begin
                need_eff = 3'd1;
            end
        end else begin
            need_eff = r_need;
        end
        complete = (cnt_inc == need_eff);
        case (need_eff)
            3'd1:    off_val = 32'(b) + 32'd1;
            3'd2:    off_val = 32'(LEAD_SHORT) + 32'(b) + 32'd1;
            3'd3:    off_val = {16'd0, r_acc[7:0], b};
            default: off_val = {r_acc[23:0], b};
        endcase
        case (r_mode)
            MODE_DELETE: off_err = ERR_DELETE;
            MODE_EQUAL:  off_err = ERR_EQUAL;
            default:     off_err = ERR_BACKTRACK;
        endcase
    end

    always_comb begin
        n_mode = r_mode;
        n_pend = r_pend;
        n_cnt  = r_cnt;
        n_need = r_need;
        n_orig = r_orig;
        n_dest = r_dest;
        acc_we = 1'b0;
        nres   = 2'd0;
        nlit   = 2'd0;
        lit0   = b;
        lit1   = b;
        pair   = '0;
        if (is_off) begin
            n_pend = 1'b0;
            if (stuck) begin
                nres      = 2'd1;
                pair.kind = OP_ERROR;
                pair.err  = off_err;
            end else begin
                n_cnt  = cnt_inc;
                acc_we = !lead;
                if (lead) begin
                    n_need = need_eff;
                end
                if (lead && (b == LEAD_BAD)) begin
                    n_need    = 3'd1;
                    nres      = 2'd1;
                    pair.kind = OP_ERROR;
                    pair.err  = off_err;
                end else if (complete && (off_val != 32'd0)) begin
                    if (off_val[31]) begin
                        nres      = 2'd1;
                        pair.kind = OP_ERROR;
                        pair.err  = off_err;
                    end else begin
                        n_mode = MODE_NONE;
                        if (r_mode == MODE_DELETE) begin
                            n_orig = r_orig + t_addr'(off_val);
                        end else if (r_mode == MODE_BACKTRACK) begin
                            n_orig = r_orig - t_addr'(off_val);
                        end else begin
                            nres      = 2'd1;
                            pair.kind = OP_COPY;
                            pair.dest0 = 32'(r_dest);
                            pair.src  = 32'(r_orig);
                            pair.len  = off_val[30:0];
                            n_dest    = r_dest + t_addr'(off_val);
                            n_orig    = r_orig + t_addr'(off_val);
                        end
                    end
                end
            end
        end else begin
            if (r_pend) begin
                n_pend = 1'b0;
                if (cmd != MODE_NONE) begin
                    n_mode = cmd;
                    n_cnt  = 3'd0;
                    n_need = 3'd0;
                end else if (b == i_cfg.esc_code) begin
                    nlit = 2'd1;
                end else begin
                    nlit = 2'd2;
                    lit0 = i_cfg.esc_code;
                end
            end else begin
                n_pend = (b == i_cfg.esc_code);
                if (b != i_cfg.esc_code) begin
                    nlit = 2'd1;
                end
            end
            if (nlit != 2'd0) begin
                nres     = nlit;
                pair.two = (nlit == 2'd2);
                if ((r_mode == MODE_MODIFY) || (r_mode == MODE_INSERT)) begin
                    pair.kind  = OP_WRITE;
                    pair.dest0 = 32'(r_dest);
                    pair.dest1 = 32'(r_dest + t_addr'(1));
                    pair.data0 = lit0;
                    pair.data1 = lit1;
                    n_dest     = r_dest + t_addr'(nlit);
                    if (r_mode == MODE_MODIFY) begin
                        n_orig = r_orig + t_addr'(nlit);
                    end
                end else begin
                    pair.kind = OP_ERROR;
                    pair.err  = ERR_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_NONE;
            r_pend     <= 1'b0;
            r_cnt      <= 3'd0;
            r_need     <= 3'd0;
            r_orig     <= '0;
            r_dest     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_mode <= n_mode;
                r_pend <= n_pend;
                r_cnt  <= n_cnt;
                r_need <= n_need;
                r_orig <= n_orig;
                r_dest <= n_dest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_patch_byte;
        end
        if (fire && acc_we) begin
            r_acc <= {r_acc[15:0], b};
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bpsd_outq.sv @@
//------------------------------------------------------------------------------
// bpsd_outq
// Two-entry result queue that unpacks each result pair into single items.
//------------------------------------------------------------------------------
`default_nettype none

module bpsd_outq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire bpsd_pkg::t_pair i_pair,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [1:0]           o_op_kind,
    output logic [31:0]          o_dest_addr,
    output logic [31:0]          o_src_addr,
    output logic [7:0]           o_data_byte,
    output logic [30:0]          o_copy_length,
    output logic [1:0]           o_error_code,
    output logic                 o_last_of_run
);
    import bpsd_pkg::*;

    t_pair      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       r_sub;
    t_pair      head;
    logic       pop;
    logic       entry_done;

    assign head       = r_mem[r_rd_ptr];
    assign o_full     = (r_count == 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign pop        = o_valid && !i_stall;
    assign entry_done = pop && (r_sub || !head.two);

    assign o_op_kind     = head.kind;
    assign o_dest_addr   = r_sub ? head.dest1 : head.dest0;
    assign o_src_addr    = head.src;
    assign o_data_byte   = r_sub ? head.data1 : head.data0;
    assign o_copy_length = head.len;
    assign o_error_code  = head.err;
    assign o_last_of_run = r_sub || !head.two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (entry_done) begin
                r_rd_ptr <= !r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (pop) begin
                r_sub <= 1'b1;
            end
            r_count <= r_count + 2'(i_push) - 2'(entry_done);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/binary_patch_stream_decoder_unit.sv @@
//------------------------------------------------------------------------------
// binary_patch_stream_decoder_unit
// Escape-coded binary patch decoder producing byte writes, copy runs and errors.
//------------------------------------------------------------------------------
// The block takes one patch byte per cycle while o_stall is low. A byte is
// decoded while it sits in the input register, against the mode, escape and
// offset state, and its results enter a two-entry queue that feeds the
// output once the queue has room; the first result of a byte is offered from
// the queue. Most bytes give at most one result and flow at one item per cycle
// while the output does not stall. An escape followed by a plain byte gives two
// results, which leave one after the other and can hold the input under a steady stream.
`default_nettype none

module binary_patch_stream_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_patch_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_op_kind,
    output logic [31:0]      o_dest_addr,
    output logic [31:0]      o_src_addr,
    output logic [7:0]       o_data_byte,
    output logic [30:0]      o_copy_length,
    output logic [1:0]       o_error_code,
    output logic             o_last_of_run
);
    import bpsd_pkg::*;

    t_cfg  r_cfg;
    t_pair pair;
    logic  push;
    logic  q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.esc_code <= RST_ESCAPE;
            r_cfg.mod_code <= RST_MODIFY;
            r_cfg.ins_code <= RST_INSERT;
            r_cfg.del_code <= RST_DELETE;
            r_cfg.eql_code <= RST_EQUAL;
            r_cfg.bkt_code <= RST_BACKTRACK;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ESCAPE:    r_cfg.esc_code <= i_cfg_wdata;
                CFG_MODIFY:    r_cfg.mod_code <= i_cfg_wdata;
                CFG_INSERT:    r_cfg.ins_code <= i_cfg_wdata;
                CFG_DELETE:    r_cfg.del_code <= i_cfg_wdata;
                CFG_EQUAL:     r_cfg.eql_code <= i_cfg_wdata;
                CFG_BACKTRACK: r_cfg.bkt_code <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bpsd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .i_patch_byte (i_patch_byte),
        .o_stall      (o_stall),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_pair       (pair)
    );

    bpsd_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_pair        (pair),
        .o_full        (q_full),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_op_kind     (o_op_kind),
        .o_dest_addr   (o_dest_addr),
        .o_src_addr    (o_src_addr),
        .o_data_byte   (o_data_byte),
        .o_copy_length (o_copy_length),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("result pushed into a full queue");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_run) |=> o_valid)
        else $error("second result of a byte went missing");

    a_pair_not_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> (o_op_kind != OP_COPY))
        else $error("copy run reported as part of a pair");

    a_copy_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_op_kind == OP_COPY)) |-> (o_copy_length != 31'd0))
        else $error("copy run with zero length");

endmodule

`default_nettype wire

@@ dv/tb_binary_patch_stream_decoder_unit.sv @@
//------------------------------------------------------------------------------
// tb_binary_patch_stream_decoder_unit
// Self-checking testbench for the escape-coded binary patch decoder.
//------------------------------------------------------------------------------
// Patch bytes are queued by the stimulus process and offered by a driver with
// random gaps. Every accepted byte is decoded by a behavioral model of the
// command stream, and the byte writes, copy runs and errors that it predicts
// are matched field by field against the results taken by the monitor under
// random output stalls. The run steps through several command code settings,
// covers escaped literals, all offset formats and overlapping codes, applies
// one long output hold-off, and ends with offsets that lock the decoder into
// its error state.
//------------------------------------------------------------------------------
module tb_binary_patch_stream_decoder_unit;

    import bpsd_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 5000;

    localparam int OFF_BAD = -1;
    localparam int OFF_PENDING = 0;
    localparam int OFF_DONE = 1;

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_MODIFY,
        MODE_INSERT,
        MODE_DELETE,
        MODE_EQUAL,
        MODE_BACKTRACK
    } t_mode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] dest;
        logic [31:0] src;
        logic [7:0]  data;
        logic [30:0] len;
        logic [1:0]  err;
        logic        last;
    } t_patch_op;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        patch_valid = 1'b0;
    logic        patch_stall;
    logic [7:0]  patch_byte = '0;
    logic        op_valid;
    logic        op_stall = 1'b0;
    logic [1:0]  op_kind;
    logic [31:0] op_dest_addr;
    logic [31:0] op_src_addr;
    logic [7:0]  op_data_byte;
    logic [30:0] op_copy_length;
    logic [1:0]  op_error_code;
    logic        op_last_of_run;

    wire patch_accept = patch_valid && !patch_stall;
    wire op_accept = op_valid && !op_stall;

    logic [7:0] code_table [0:5];
    t_mode      dec_mode;
    logic       esc_seen;
    logic [7:0] off_bytes [0:4];
    int         off_count;
    int         off_needed;
    t_addr      orig_ptr;
    t_addr      dest_ptr;

    logic [7:0] pending_bytes [$];
    t_patch_op  byte_ops [$];
    t_patch_op  expected_ops [$];

    int   bytes_pushed = 0;
    int   mismatch_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_req = 0;
    int   hold_ack = 0;
    int   hold_left = 0;

    binary_patch_stream_decoder_unit uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .i_valid       (patch_valid),
        .o_stall       (patch_stall),
        .i_patch_byte  (patch_byte),
        .o_valid       (op_valid),
        .i_stall       (op_stall),
        .o_op_kind     (op_kind),
        .o_dest_addr   (op_dest_addr),
        .o_src_addr    (op_src_addr),
        .o_data_byte   (op_data_byte),
        .o_copy_length (op_copy_length),
        .o_error_code  (op_error_code),
        .o_last_of_run (op_last_of_run)
    );

    always #2 clk = ~clk;

    task automatic reset_decoder_model();
        code_table[CFG_ESCAPE] = RST_ESCAPE;
        code_table[CFG_MODIFY] = RST_MODIFY;
        code_table[CFG_INSERT] = RST_INSERT;
        code_table[CFG_DELETE] = RST_DELETE;
        code_table[CFG_EQUAL] = RST_EQUAL;
        code_table[CFG_BACKTRACK] = RST_BACKTRACK;
        dec_mode = MODE_NONE;
        esc_seen = 1'b0;
        off_count = 0;
        off_needed = 0;
        orig_ptr = '0;
        dest_ptr = '0;
    endtask

    function automatic t_mode mode_of_command(input logic [7:0] b);
        if (b == code_table[CFG_MODIFY]) return MODE_MODIFY;
        if (b == code_table[CFG_INSERT]) return MODE_INSERT;
        if (b == code_table[CFG_DELETE]) return MODE_DELETE;
        if (b == code_table[CFG_EQUAL]) return MODE_EQUAL;
        if (b == code_table[CFG_BACKTRACK]) return MODE_BACKTRACK;
        return MODE_NONE;
    endfunction

    function automatic int take_offset_byte(input logic [7:0] b, output logic [31:0] value);
        logic [31:0] v;
        value = '0;
        if (off_count != 0 && off_count == off_needed) return OFF_BAD;
        if (off_count >= OFF_MAX_BYTES) return OFF_BAD;
        off_bytes[off_count] = b;
        off_count++;
        if (off_count == 1) begin
            if (b == LEAD_BAD) begin
                off_needed = 1;
                return OFF_BAD;
            end
            off_needed = (b == LEAD_32) ? 5 : (b == LEAD_16) ? 3 : (b == LEAD_SHORT) ? 2 : 1;
        end
        if (off_count != off_needed) return OFF_PENDING;
        case (off_needed)
            1: v = {24'h0, off_bytes[0]} + 32'd1;
            2: v = {24'h0, off_bytes[0]} + {24'h0, off_bytes[1]} + 32'd1;
            3: v = {16'h0, off_bytes[1], off_bytes[2]};
            default: v = {off_bytes[1], off_bytes[2], off_bytes[3], off_bytes[4]};
        endcase
        if (v == 0) return OFF_PENDING;
        if (v[31]) return OFF_BAD;
        value = v;
        return OFF_DONE;
    endfunction

    task automatic add_op(input logic [1:0] kind, input t_addr dest, input t_addr src,
                          input logic [7:0] data, input logic [30:0] len,
                          input logic [1:0] err);
        t_patch_op op;
        op.kind = kind;
        op.dest = dest[31:0];
        op.src = src[31:0];
        op.data = data;
        op.len = len;
        op.err = err;
        op.last = 1'b0;
        byte_ops.push_back(op);
    endtask

    task automatic apply_symbol(input logic [7:0] b);
        logic [31:0] value;
        int status;
        logic [1:0] err;
        case (dec_mode)
            MODE_MODIFY: begin
                add_op(OP_WRITE, dest_ptr, '0, b, '0, ERR_NONE);
                dest_ptr = dest_ptr + 1;
                orig_ptr = orig_ptr + 1;
            end
            MODE_INSERT: begin
                add_op(OP_WRITE, dest_ptr, '0, b, '0, ERR_NONE);
                dest_ptr = dest_ptr + 1;
            end
            MODE_DELETE, MODE_EQUAL, MODE_BACKTRACK: begin
                status = take_offset_byte(b, value);
                if (status == OFF_BAD) begin
                    err = (dec_mode == MODE_DELETE) ? ERR_DELETE :
                          (dec_mode == MODE_EQUAL) ? ERR_EQUAL : ERR_BACKTRACK;
                    add_op(OP_ERROR, '0, '0, '0, '0, err);
                end else if (status == OFF_DONE) begin
                    if (dec_mode == MODE_DELETE) begin
                        orig_ptr = orig_ptr + value;
                    end else if (dec_mode == MODE_BACKTRACK) begin
                        orig_ptr = orig_ptr - value;
                    end else begin
                        add_op(OP_COPY, dest_ptr, orig_ptr, '0, value[30:0], ERR_NONE);
                        dest_ptr = dest_ptr + value;
                        orig_ptr = orig_ptr + value;
                    end
                    dec_mode = MODE_NONE;
                end
            end
            default: begin
                add_op(OP_ERROR, '0, '0, '0, '0, ERR_NONE);
            end
        endcase
    endtask

    task automatic decode_patch_byte(input logic [7:0] b);
        t_mode cmd;
        t_patch_op op;
        logic [7:0] esc;
        esc = code_table[CFG_ESCAPE];
        if (dec_mode == MODE_DELETE || dec_mode == MODE_EQUAL || dec_mode == MODE_BACKTRACK) begin
            apply_symbol(b);
            esc_seen = 1'b0;
        end else if (esc_seen) begin
            cmd = mode_of_command(b);
            if (cmd != MODE_NONE) begin
                dec_mode = cmd;
                off_count = 0;
                off_needed = 0;
            end else if (b == esc) begin
                apply_symbol(b);
            end else begin
                apply_symbol(esc);
                apply_symbol(b);
            end
            esc_seen = 1'b0;
        end else begin
            if (b != esc) apply_symbol(b);
            esc_seen = (b == esc);
        end
        while (byte_ops.size() != 0) begin
            op = byte_ops.pop_front();
            op.last = (byte_ops.size() == 0);
            expected_ops.push_back(op);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_pushed++;
    endtask

    // A literal is either a plain byte or an escape followed by a byte that
    // is no command code, which yields one or two literals.
    task automatic push_literal();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if ($urandom_range(7) == 0) begin
            if ($urandom_range(1) == 0) b = code_table[CFG_ESCAPE];
            while (mode_of_command(b) != MODE_NONE) b = 8'($urandom_range(255));
            push_byte(code_table[CFG_ESCAPE]);
            push_byte(b);
        end else begin
            while (b == code_table[CFG_ESCAPE]) b = 8'($urandom_range(255));
            push_byte(b);
        end
    endtask

    task automatic push_offset();
        logic [31:0] v;
        case ($urandom_range(3))
            0: push_byte(8'($urandom_range(251)));
            1: begin
                push_byte(LEAD_SHORT);
                push_byte(8'($urandom_range(255)));
            end
            2: begin
                v = $urandom_range(65535, 1);
                push_byte(LEAD_16);
                push_byte(v[15:8]);
                push_byte(v[7:0]);
            end
            default: begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'd1;
                    2: v = $urandom_range(65535, 1);
                    default: v = $urandom() & 32'h7FFF_FFFF;
                endcase
                if (v == 0) v = 32'd1;
                push_byte(LEAD_32);
                push_byte(v[31:24]);
                push_byte(v[23:16]);
                push_byte(v[15:8]);
                push_byte(v[7:0]);
            end
        endcase
    endtask

    task automatic push_command_run();
        logic [7:0] code;
        t_mode m;
        code = code_table[$urandom_range(CFG_BACKTRACK, CFG_MODIFY)];
        m = mode_of_command(code);
        push_byte(code_table[CFG_ESCAPE]);
        push_byte(code);
        if (m == MODE_MODIFY || m == MODE_INSERT) begin
            repeat ($urandom_range(8)) push_literal();
        end else begin
            push_offset();
        end
    endtask

    task automatic push_random_bytes(input int count);
        int stop;
        int r;
        stop = bytes_pushed + count;
        while (bytes_pushed < stop) begin
            r = $urandom_range(99);
            if (r < 70) begin
                push_command_run();
            end else if (r < 90) begin
                push_literal();
            end else begin
                push_byte(code_table[CFG_ESCAPE]);
                push_byte(code_table[$urandom_range(CFG_INSERT, CFG_MODIFY)]);
            end
        end
    endtask

    // Any of these offsets leaves the decoder reporting errors for good, so
    // they come last. The first one in the list is the one that takes effect.
    task automatic push_locking_offsets();
        int first;
        first = $urandom_range(2);
        for (int k = 0; k < 3; k++) begin
            push_byte(code_table[CFG_ESCAPE]);
            case ((first + k) % 3)
                0: begin
                    push_byte(code_table[CFG_DELETE]);
                    push_byte(LEAD_BAD);
                end
                1: begin
                    push_byte(code_table[CFG_EQUAL]);
                    push_byte(LEAD_32);
                    push_byte(8'h80 | 8'($urandom_range(127)));
                    repeat (3) push_byte(8'($urandom_range(255)));
                end
                default: begin
                    push_byte(code_table[CFG_BACKTRACK]);
                    push_byte(LEAD_16);
                    push_byte(8'h00);
                    push_byte(8'h00);
                end
            endcase
        end
        repeat (12) push_byte(8'($urandom_range(255)));
    endtask

    task automatic wait_for_drain();
        while (pending_bytes.size() != 0 || patch_valid || expected_ops.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_codes(input logic [7:0] esc, input logic [7:0] modify,
                               input logic [7:0] insert, input logic [7:0] delete_c,
                               input logic [7:0] equal_c, input logic [7:0] back);
        logic [7:0] vals [0:5];
        vals[CFG_ESCAPE] = esc;
        vals[CFG_MODIFY] = modify;
        vals[CFG_INSERT] = insert;
        vals[CFG_DELETE] = delete_c;
        vals[CFG_EQUAL] = equal_c;
        vals[CFG_BACKTRACK] = back;
        for (int idx = CFG_ESCAPE; idx <= CFG_BACKTRACK; idx++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[2:0];
            cfg_wdata <= vals[idx];
            @(posedge clk);
            code_table[idx] = vals[idx];
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            patch_valid <= 1'b0;
        end else begin
            if (patch_accept) decode_patch_byte(patch_byte);
            if (!patch_valid || !patch_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    patch_valid <= 1'b1;
                    patch_byte <= pending_bytes.pop_front();
                end else begin
                    patch_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            op_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            op_stall <= 1'b1;
        end else begin
            op_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin : result_monitor
        t_patch_op want;
        if (rst_n && op_accept) begin
            if (expected_ops.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d dest %0h",
                         $time, op_kind, op_dest_addr);
                mismatch_count++;
            end else begin
                want = expected_ops.pop_front();
                check_field("op_kind", 32'(want.kind), 32'(op_kind));
                check_field("dest_addr", want.dest, op_dest_addr);
                check_field("src_addr", want.src, op_src_addr);
                check_field("data_byte", 32'(want.data), 32'(op_data_byte));
                check_field("copy_length", 32'(want.len), 32'(op_copy_length));
                check_field("error_code", 32'(want.err), 32'(op_error_code));
                check_field("last_of_run", 32'(want.last), 32'(op_last_of_run));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || patch_accept || op_accept) quiet = 0;
            else quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] directed [$];
        reset_decoder_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        directed = '{8'h00,
                     RST_ESCAPE, RST_ESCAPE,
                     RST_ESCAPE, 8'h55,
                     RST_ESCAPE, RST_MODIFY, 8'hFF, RST_ESCAPE, 8'h00,
                     RST_ESCAPE, RST_INSERT, RST_ESCAPE, RST_ESCAPE,
                     RST_ESCAPE, RST_DELETE, LEAD_SHORT, 8'hFF,
                     RST_ESCAPE, RST_BACKTRACK, LEAD_16, 8'h01, 8'h00,
                     RST_ESCAPE, RST_EQUAL, RST_ESCAPE};
        foreach (directed[k]) push_byte(directed[k]);
        push_random_bytes(300);
        wait_for_drain();

        write_codes(8'd0, 8'd255, 8'd1, 8'd254, 8'd2, 8'd253);
        send_idle_pct <= 55;
        push_random_bytes(250);
        wait_for_drain();

        write_codes(8'd255, 8'd0, 8'd128, 8'd127, 8'd254, 8'd1);
        send_idle_pct <= 0;
        recv_stall_pct <= 55;
        push_random_bytes(250);
        wait_for_drain();

        // Escape doubles as the modify code and two other codes are shadowed.
        write_codes(8'd90, 8'd90, 8'd17, 8'd17, 8'd200, 8'd90);
        send_idle_pct <= 6;
        recv_stall_pct <= 6;
        push_random_bytes(200);
        wait_for_drain();

        write_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
        hold_req <= hold_req + 1;
        push_random_bytes(250);
        wait_for_drain();

        write_codes(RST_ESCAPE, RST_MODIFY, RST_INSERT, RST_DELETE, RST_EQUAL,
                    RST_BACKTRACK);
        send_idle_pct <= 55;
        recv_stall_pct <= 55;
        push_random_bytes(150);
        push_locking_offsets();
        wait_for_drain();

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
